// ----- src/glos_pkg.sv -----
// Shared types and constants for the grid line-of-sight checker.
// Used by glos_front, glos_queue, glos_back and the top level.
`default_nettype none

package glos_pkg;

    localparam int COORD_W     = 6;  // width of one grid coordinate
    localparam int DIM_CFG_W   = 7;  // width of the size registers
    localparam int CFG_IDX_W   = 2;
    localparam int ERR_W       = 9;  // Bresenham error term, signed
    localparam int E2_W        = ERR_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // One classified command as it travels from the front to the back
    typedef struct packed {
        logic                     is_query;
        logic [COORD_W-1:0]       x0;
        logic [COORD_W-1:0]       y0;
        logic [COORD_W-1:0]       x1;
        logic [COORD_W-1:0]       y1;
        logic                     cell_val;
        logic [COORD_W-1:0]       dx;
        logic [COORD_W-1:0]       dy_mag;
        logic                     x_neg;
        logic                     y_neg;
        logic signed [ERR_W-1:0]  err0;
    } glos_cmd_t;

    typedef struct packed {
        logic clearing;
        logic in_query;
    } glos_status_t;

endpackage

`default_nettype wire

// ----- src/glos_front.sv -----
// Front end: accepts input words, classifies them and precomputes the line setup.
// Depends on glos_pkg.
`default_nettype none

module glos_front
    import glos_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               hold,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [COORD_W-1:0] s_start_x,
    input  wire logic [COORD_W-1:0] s_start_y,
    input  wire logic [COORD_W-1:0] s_end_x,
    input  wire logic [COORD_W-1:0] s_end_y,
    input  wire logic               s_cell_value,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output glos_cmd_t               cmd
);

    logic      valid_reg;
    glos_cmd_t cmd_reg;
    glos_cmd_t cmd_next;
    logic      accept;

    assign s_ready   = !hold && (!valid_reg || cmd_ready);
    assign accept    = s_valid && s_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.is_query = (s_mode == MODE_QUERY);
        cmd_next.x0       = s_start_x;
        cmd_next.y0       = s_start_y;
        cmd_next.x1       = s_end_x;
        cmd_next.y1       = s_end_y;
        cmd_next.cell_val = s_cell_value;
        cmd_next.dx       = (s_end_x > s_start_x) ? (s_end_x - s_start_x)
                                                  : (s_start_x - s_end_x);
        cmd_next.dy_mag   = (s_end_y > s_start_y) ? (s_end_y - s_start_y)
                                                  : (s_start_y - s_end_y);
        cmd_next.x_neg    = !(s_start_x < s_end_x);
        cmd_next.y_neg    = !(s_start_y < s_end_y);
        cmd_next.err0     = ERR_W'(cmd_next.dx) - ERR_W'(cmd_next.dy_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/glos_queue.sv -----
// Short command queue between the front end and the line walker.
// Depends on glos_pkg.
`default_nettype none

module glos_queue
    import glos_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire glos_cmd_t in_cmd,
    output logic           out_valid,
    input  wire logic      out_ready,
    output glos_cmd_t      out_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    glos_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/glos_back.sv -----
// Back end: occupancy bitmap, clearing pass, Bresenham walker and result register.
// Depends on glos_pkg.
`default_nettype none

module glos_back
    import glos_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire glos_cmd_t            cmd,
    input  wire logic [DIM_CFG_W-1:0] lim_w,
    input  wire logic [DIM_CFG_W-1:0] lim_h,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_clear,
    output glos_status_t              status
);

    localparam int RW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int XW  = (RW > COORD_W) ? RW : COORD_W;
    localparam int LW0 = $clog2(MAX_DIM + 1);
    localparam int LW  = (LW0 > DIM_CFG_W) ? LW0 : DIM_CFG_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } glos_state_t;

    glos_state_t state_reg;

    logic [MAX_DIM-1:0] mem_q [MAX_DIM];
    logic [MAX_DIM-1:0] rd_row_reg;
    logic [RW-1:0]      clr_row_reg;

    // walk position, issue side
    logic                    run_reg;
    logic [COORD_W-1:0]      wx_reg;
    logic [COORD_W-1:0]      wy_reg;
    logic [COORD_W-1:0]      ex_reg;
    logic [COORD_W-1:0]      ey_reg;
    logic [COORD_W-1:0]      dx_reg;
    logic [COORD_W-1:0]      dym_reg;
    logic                    nx_reg;
    logic                    ny_reg;
    logic signed [ERR_W-1:0] err_reg;

    // check side, registered alongside the bitmap row read
    logic               chk_valid_reg;
    logic [COORD_W-1:0] chk_x_reg;
    logic [COORD_W-1:0] chk_y_reg;
    logic               chk_last_reg;

    logic res_valid_reg;
    logic res_clear_reg;
    logic pend_clear_reg;

    logic                    pop;
    logic                    wr_en;
    logic [XW-1:0]           wr_x_ext;
    logic [XW-1:0]           wr_y_ext;
    logic [XW-1:0]           rd_y_ext;
    logic [XW-1:0]           chk_x_ext;
    logic [RW-1:0]           rd_idx;
    logic                    walk_last;
    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  err_s;
    logic signed [E2_W-1:0]  dx_s;
    logic signed [E2_W-1:0]  dyn_s;
    logic signed [E2_W-1:0]  sum_s;
    logic                    step_x;
    logic                    step_y;
    logic                    chk_ok;
    logic                    fin;
    logic                    out_free;
    logic                    res_load;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign wr_x_ext  = XW'(cmd.x0);
    assign wr_y_ext  = XW'(cmd.y0);
    assign wr_en     = pop && !cmd.is_query
                       && (LW'(cmd.x0) < LW'(MAX_DIM)) && (LW'(cmd.y0) < LW'(MAX_DIM));

    // row read address, held in range for narrow grids
    assign rd_y_ext  = XW'(wy_reg);
    assign rd_idx    = (LW'(wy_reg) < LW'(MAX_DIM)) ? rd_y_ext[RW-1:0] : '0;
    assign chk_x_ext = XW'(chk_x_reg);

    // error-term step with independent x and y moves
    assign walk_last = (wx_reg == ex_reg) && (wy_reg == ey_reg);
    assign err_s     = E2_W'(err_reg);
    assign e2        = {err_reg, 1'b0};
    assign dx_s      = E2_W'(dx_reg);
    assign dyn_s     = E2_W'(0) - E2_W'(dym_reg);
    assign step_x    = (e2 >= dyn_s);
    assign step_y    = (e2 <= dx_s);
    assign sum_s     = err_s + (step_x ? dyn_s : E2_W'(0)) + (step_y ? dx_s : E2_W'(0));

    assign chk_ok   = (LW'(chk_x_reg) < LW'(lim_w)) && (LW'(chk_y_reg) < LW'(lim_h))
                      && !rd_row_reg[chk_x_ext[RW-1:0]];
    assign fin      = (state_reg == ST_WALK) && chk_valid_reg && (!chk_ok || chk_last_reg);
    assign out_free = !res_valid_reg || m_ready;
    assign res_load = (fin || (state_reg == ST_DONE)) && out_free;

    assign m_valid         = res_valid_reg;
    assign m_clear         = res_clear_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.in_query = (state_reg == ST_WALK) || (state_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            run_reg       <= 1'b0;
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_row_reg <= clr_row_reg + 1'b1;
                    if (clr_row_reg == RW'(MAX_DIM - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop && cmd.is_query) begin
                        state_reg     <= ST_WALK;
                        run_reg       <= 1'b1;
                        chk_valid_reg <= 1'b0;
                    end
                end
                ST_WALK: begin
                    // first failing cell or the end cell closes the walk
                    if (fin) begin
                        run_reg       <= 1'b0;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= out_free ? ST_IDLE : ST_DONE;
                    end else begin
                        chk_valid_reg <= run_reg;
                        if (run_reg && walk_last) begin
                            run_reg <= 1'b0;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && cmd.is_query) begin
            wx_reg  <= cmd.x0;
            wy_reg  <= cmd.y0;
            ex_reg  <= cmd.x1;
            ey_reg  <= cmd.y1;
            dx_reg  <= cmd.dx;
            dym_reg <= cmd.dy_mag;
            nx_reg  <= cmd.x_neg;
            ny_reg  <= cmd.y_neg;
            err_reg <= cmd.err0;
        end else if ((state_reg == ST_WALK) && run_reg && !walk_last) begin
            if (step_x) begin
                wx_reg <= nx_reg ? (wx_reg - 1'b1) : (wx_reg + 1'b1);
            end
            if (step_y) begin
                wy_reg <= ny_reg ? (wy_reg - 1'b1) : (wy_reg + 1'b1);
            end
            err_reg <= ERR_W'(sum_s);
        end
        chk_x_reg    <= wx_reg;
        chk_y_reg    <= wy_reg;
        chk_last_reg <= walk_last;
        if (fin) begin
            pend_clear_reg <= chk_ok;
        end
        if (res_load) begin
            res_clear_reg <= (state_reg == ST_WALK) ? chk_ok : pend_clear_reg;
        end
    end

    // occupancy bitmap: one row per entry, registered row read
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            mem_q[clr_row_reg] <= '0;
        end else if (wr_en) begin
            mem_q[wr_y_ext[RW-1:0]][wr_x_ext[RW-1:0]] <= cmd.cell_val;
        end
        rd_row_reg <= mem_q[rd_idx];
    end

endmodule

`default_nettype wire

// ----- src/grid_line_of_sight_checker_unit.sv -----
// Grid line-of-sight checker, top level: size registers, front end, queue, walker.
// Depends on glos_pkg, glos_front, glos_queue and glos_back.
//
// Input words on s_*: mode 0 stores s_cell_value at (s_start_x, s_start_y) and
// gives no result; mode 1 walks the Bresenham line from start to end and returns
// one word on m_clear: 1 when every cell on the line is inside the configured
// width and height and free. Size registers are written on the cfg_* channel
// (index 0 width, index 1 height); cfg_ready is always high.
// A word passes a front register and a two-entry queue before the walker sees it.
// A write is stored in the bitmap when the walker takes it from idle. A query takes one
// bitmap row read per visited cell through the registered read and holds the walker
// until its walk ends; the walk ends early at the first blocked or outside cell. The
// single-port bitmap read sets the pace of one row read per visited cell.
// After reset the bitmap is cleared one row per cycle, with s_ready held low; both
// sizes reset to 64. When m_ready stays low the result holds in its register, the
// walker keeps one more finished answer, and the queue and front register keep
// taking words until they fill.
`default_nettype none

module grid_line_of_sight_checker_unit
    import glos_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [COORD_W-1:0]   s_start_x,
    input  wire logic [COORD_W-1:0]   s_start_y,
    input  wire logic [COORD_W-1:0]   s_end_x,
    input  wire logic [COORD_W-1:0]   s_end_y,
    input  wire logic                 s_cell_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_clear,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_CFG_W-1:0] cfg_data
);

    localparam int LW0 = $clog2(MAX_DIM + 1);
    localparam int LW  = (LW0 > DIM_CFG_W) ? LW0 : DIM_CFG_W;

    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic [DIM_CFG_W-1:0] lim_w;
    logic [DIM_CFG_W-1:0] lim_h;

    logic         f_valid;
    logic         f_ready;
    glos_cmd_t    f_cmd;
    logic         q_valid;
    logic         q_ready;
    glos_cmd_t    q_cmd;
    glos_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GRID_WIDTH:  width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturate sizes to the bitmap dimension; the result never exceeds the register
    assign lim_w = (LW'(width_reg) > LW'(MAX_DIM)) ? DIM_CFG_W'(MAX_DIM) : width_reg;
    assign lim_h = (LW'(height_reg) > LW'(MAX_DIM)) ? DIM_CFG_W'(MAX_DIM) : height_reg;

    glos_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .hold         (status.clearing),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_cell_value (s_cell_value),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd          (f_cmd)
    );

    glos_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    glos_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .lim_w     (lim_w),
        .lim_h     (lim_h),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_clear   (m_clear),
        .status    (status)
    );

    // no input word is taken while the bitmap is being cleared
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready
    ) else $error("input accepted during bitmap clearing pass");

    // a new result only comes out of a query walk
    a_result_from_walk: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(status.in_query)
    ) else $error("result raised without a query in progress");

    // the clearing pass runs once per reset
    a_clear_once: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !status.clearing |=> !status.clearing
    ) else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

// ----- tb/sight_line_monitor.sv -----
`timescale 1ns / 100ps
// Checker for the grid line-of-sight unit: mirrors the occupancy map and grid size,
// predicts the clear flag of every query word and compares it on m_*. Needs glos_pkg.

module sight_line_monitor
    import glos_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_mode,
    input  wire logic [COORD_W-1:0]   s_start_x,
    input  wire logic [COORD_W-1:0]   s_start_y,
    input  wire logic [COORD_W-1:0]   s_end_x,
    input  wire logic [COORD_W-1:0]   s_end_y,
    input  wire logic                 s_cell_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic                 m_clear,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_CFG_W-1:0] cfg_data,
    output int                        pending_results,
    output int                        mismatch_count
);

    typedef struct {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               clear;
    } sight_query_t;

    logic [MAX_DIM-1:0]   occ_rows [MAX_DIM];
    logic [DIM_CFG_W-1:0] grid_width;
    logic [DIM_CFG_W-1:0] grid_height;
    sight_query_t         clear_expected_q [$];

    function automatic int clamp_dim(input logic [DIM_CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic bit cell_free(input int x, input int y);
        if (x < 0 || y < 0 || x >= clamp_dim(grid_width) || y >= clamp_dim(grid_height))
            return 1'b0;
        return !occ_rows[y][x];
    endfunction

    // Bresenham walk with independent x and y steps; stop at the first bad cell
    function automatic logic predict_line_clear(input logic [COORD_W-1:0] x0, y0, x1, y1);
        int dx, dy, step_x, step_y, err, e2, cx, cy, guard;
        dx = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        dy = (y1 > y0) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
        step_x = (x0 < x1) ? 1 : -1;
        step_y = (y0 < y1) ? 1 : -1;
        err = dx + dy;
        cx = int'(x0);
        cy = int'(y0);
        guard = dx - dy + 2;
        while (guard > 0) begin
            guard--;
            if (!cell_free(cx, cy))
                return 1'b0;
            if (cx == int'(x1) && cy == int'(y1))
                return 1'b1;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                cx += step_x;
            end
            if (e2 <= dx) begin
                err += dx;
                cy += step_y;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        sight_query_t q;
        if (!aresetn) begin
            for (int r = 0; r < MAX_DIM; r++)
                occ_rows[r] = '0;
            grid_width = DIM_RESET;
            grid_height = DIM_RESET;
            clear_expected_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_GRID_WIDTH)
                    grid_width = cfg_data;
                else if (cfg_index == CFG_GRID_HEIGHT)
                    grid_height = cfg_data;
            end
            // retire before predicting: a result can never belong to this edge's word
            if (m_valid && m_ready) begin
                if (clear_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result word clear=%b with no query waiting",
                                              m_clear));
                end else begin
                    q = clear_expected_q.pop_front();
                    if (m_clear !== q.clear)
                        report_mismatch($sformatf(
                            "line (%0d,%0d)->(%0d,%0d): clear=%b, predicted %b",
                            q.x0, q.y0, q.x1, q.y1, m_clear, q.clear));
                end
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_QUERY) begin
                    q.x0 = s_start_x;
                    q.y0 = s_start_y;
                    q.x1 = s_end_x;
                    q.y1 = s_end_y;
                    q.clear = predict_line_clear(s_start_x, s_start_y, s_end_x, s_end_y);
                    clear_expected_q = {clear_expected_q, q};
                end else if (s_start_x < MAX_DIM && s_start_y < MAX_DIM) begin
                    occ_rows[s_start_y][s_start_x] = s_cell_value;
                end
            end
        end
        pending_results <= clear_expected_q.size();
    end

endmodule

// ----- tb/grid_line_of_sight_checker_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench top for grid_line_of_sight_checker_unit: drives words and size writes,
// toggles m_ready, gives the verdict. Needs glos_pkg and sight_line_monitor.

module grid_line_of_sight_checker_unit_test;
    import glos_pkg::*;

    localparam int GRID_DIM     = 64;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WRITE_SETTLE = 20;
    localparam int FINAL_SETTLE = 80;
    localparam int SEG_WORDS    = 150;

    // indexes past the register list: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [COORD_W-1:0]   s_start_x;
    logic [COORD_W-1:0]   s_start_y;
    logic [COORD_W-1:0]   s_end_x;
    logic [COORD_W-1:0]   s_end_y;
    logic                 s_cell_value;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_clear;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_CFG_W-1:0] cfg_data;

    int pending_results;
    int mismatch_count;
    int cycle_count;
    int sender_idle_pct;
    int receiver_idle_pct;
    int span_x;
    int span_y;

    grid_line_of_sight_checker_unit #(.MAX_DIM(GRID_DIM)) dut (.*);

    sight_line_monitor #(.MAX_DIM(GRID_DIM)) monitor (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    task automatic send_word(input logic mode, input logic [COORD_W-1:0] x0, y0, x1, y1,
                             input logic val);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_start_x <= x0;
        s_start_y <= y0;
        s_end_x <= x1;
        s_end_y <= y1;
        s_cell_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic query_line(input logic [COORD_W-1:0] x0, y0, x1, y1);
        send_word(MODE_QUERY, x0, y0, x1, y1, 1'($urandom_range(0, 1)));
    endtask

    task automatic store_cell(input logic [COORD_W-1:0] x, y, input logic val);
        send_word(MODE_WRITE, x, y, COORD_W'($urandom_range(0, COORD_MAX)),
                  COORD_W'($urandom_range(0, COORD_MAX)), val);
    endtask

    // hold the sender until every query has answered, then let trailing writes retire
    task automatic drain_results(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_grid_size(input int w, input int h);
        write_reg(CFG_GRID_WIDTH, DIM_CFG_W'(w));
        write_reg(CFG_GRID_HEIGHT, DIM_CFG_W'(h));
        cfg_valid <= 1'b0;
        span_x = (w > GRID_DIM) ? GRID_DIM : w;
        span_y = (h > GRID_DIM) ? GRID_DIM : h;
    endtask

    // mostly inside the grid in use, now and then anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int span);
        if (span == 0 || $urandom_range(0, 3) == 0)
            return COORD_W'($urandom_range(0, COORD_MAX));
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
                                                      input int span);
        int v;
        if ($urandom_range(0, 1) == 0)
            return pick_coord(span);
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return COORD_W'(v);
    endfunction

    task automatic send_random_word();
        logic [COORD_W-1:0] x0, y0;
        x0 = pick_coord(span_x);
        y0 = pick_coord(span_y);
        if ($urandom_range(0, 99) < 35)
            store_cell(x0, y0, ($urandom_range(0, 99) < 55));
        else
            query_line(x0, y0, near_coord(x0, span_x), near_coord(y0, span_y));
    endtask

    initial begin
        int w;
        int h;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_WRITE;
        s_start_x = '0;
        s_start_y = '0;
        s_end_x = '0;
        s_end_y = '0;
        s_cell_value = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data = '0;
        cycle_count = 0;
        sender_idle_pct = 27;
        receiver_idle_pct = 75;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_grid_size(64, 64);
        query_line(0, 0, 0, 0);
        query_line(0, 0, 63, 63);
        query_line(63, 63, 0, 0);
        query_line(63, 0, 0, 63);
        query_line(0, 5, 63, 0);
        query_line(2, 63, 0, 0);
        store_cell(10, 10, 1'b1);
        query_line(0, 0, 20, 20);
        query_line(10, 10, 10, 10);
        query_line(0, 10, 63, 10);
        query_line(10, 63, 10, 0);
        store_cell(10, 10, 1'b0);
        query_line(0, 0, 20, 20);
        store_cell(63, 63, 1'b1);
        query_line(0, 0, 63, 63);
        store_cell(63, 63, 1'b0);

        // zero width blocks everything; oversized height saturates
        drain_results(WRITE_SETTLE);
        set_grid_size(0, 127);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        cfg_valid <= 1'b0;
        query_line(0, 0, 0, 0);
        query_line(5, 5, 40, 9);

        // a cell stored outside the grid in use shows up once the grid grows
        drain_results(WRITE_SETTLE);
        set_grid_size(5, 3);
        store_cell(20, 20, 1'b1);
        query_line(0, 0, 4, 2);
        query_line(0, 0, 5, 0);
        drain_results(WRITE_SETTLE);
        set_grid_size(64, 64);
        query_line(15, 15, 25, 25);
        store_cell(20, 20, 1'b0);
        query_line(15, 15, 25, 25);

        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    sender_idle_pct = 27;
                    receiver_idle_pct = 75;
                end
                1: begin
                    sender_idle_pct = 75;
                    receiver_idle_pct = 27;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            case (seg)
                0: begin w = 64;  h = 64;  end
                1: begin w = 127; h = 48;  end
                2: begin w = 17;  h = 90;  end
                3: begin w = 0;   h = 64;  end
                4: begin w = 1;   h = 1;   end
                default: begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(1, 64);
                end
            endcase
            drain_results(WRITE_SETTLE);
            set_grid_size(w, h);
            repeat (SEG_WORDS) send_random_word();
        end

        drain_results(FINAL_SETTLE);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
